@@ hw/rtl/ksa_pkg.sv @@
`default_nettype none

package ksa_pkg;

   localparam int ENTRIES = 16;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int KEY_W   = 32;
   localparam int VAL_W   = 32;

   typedef enum logic {
      REQ_ADD   = 1'b0,
      REQ_DRAIN = 1'b1
   } ksa_req_kind_type;

   typedef enum logic [1:0] {
      CODE_VALID = 2'd0,
      CODE_EMPTY = 2'd1,
      CODE_FULL  = 2'd2
   } ksa_code_type;

   typedef struct packed {
      logic                     req_type;
      logic [KEY_W-1:0]         pair_key;
      logic signed [VAL_W-1:0]  pair_value;
   } ksa_req_type;

   typedef struct packed {
      logic [KEY_W-1:0]         out_key;
      logic signed [VAL_W-1:0]  out_sum;
      logic [1:0]               status;
      logic                     last;
   } ksa_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_DECIDE,
      ST_READ,
      ST_ADD,
      ST_APPEND,
      ST_DRAIN_RD,
      ST_DRAIN_OUT
   } ksa_state_type;

   typedef struct packed {
      logic capture;
      logic lookup;
      logic hit_read;
      logic update;
      logic append;
      logic drain_read;
      logic drain_out;
      logic rsp_drop;
      logic rsp_empty;
   } ksa_cmd_type;

   typedef struct packed {
      logic is_drain;
      logic hit;
      logic full;
      logic empty;
      logic drain_last;
   } ksa_flags_type;

endpackage

`default_nettype wire

@@ hw/rtl/ksa_ctrl.sv @@
`default_nettype none

module ksa_ctrl
   import ksa_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire ksa_flags_type flags,
   output ksa_cmd_type        cmd,
   output logic               busy
);

   ksa_state_type state_ff;
   ksa_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (flags.is_drain) begin
               state_in = flags.empty ? ST_IDLE : ST_DRAIN_RD;
            end else if (flags.hit) begin
               state_in = ST_READ;
            end else if (flags.full) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_APPEND;
            end
         end
         ST_READ: begin
            state_in = ST_ADD;
         end
         ST_ADD: begin
            state_in = ST_IDLE;
         end
         ST_APPEND: begin
            state_in = ST_IDLE;
         end
         ST_DRAIN_RD: begin
            state_in = ST_DRAIN_OUT;
         end
         ST_DRAIN_OUT: begin
            state_in = flags.drain_last ? ST_IDLE : ST_DRAIN_RD;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy        = 1'b0;
            cmd.capture = start;
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
         end
         ST_DECIDE: begin
            cmd.rsp_empty = flags.is_drain && flags.empty;
            cmd.rsp_drop  = !flags.is_drain && !flags.hit && flags.full;
         end
         ST_READ: begin
            cmd.hit_read = 1'b1;
         end
         ST_ADD: begin
            cmd.update = 1'b1;
         end
         ST_APPEND: begin
            cmd.append = 1'b1;
         end
         ST_DRAIN_RD: begin
            cmd.drain_read = 1'b1;
         end
         ST_DRAIN_OUT: begin
            cmd.drain_out = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ hw/rtl/ksa_datapath.sv @@
`default_nettype none

module ksa_datapath
   import ksa_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire ksa_req_type   req_data,
   input  wire ksa_cmd_type   cmd,
   output ksa_flags_type      flags,
   output ksa_rsp_type        rsp_data,
   output logic               strobe
);

   function automatic logic [VAL_W-1:0] sat_add(input logic [VAL_W-1:0] a,
                                                input logic [VAL_W-1:0] b);
      logic [VAL_W:0] s;
      s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
      if (s[VAL_W] != s[VAL_W-1]) begin
         sat_add = s[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
      end else begin
         sat_add = s[VAL_W-1:0];
      end
   endfunction

   ksa_req_type       req_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              hit_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [IDX_W-1:0]  drain_idx_ff;
   logic [KEY_W-1:0]  key_ff [ENTRIES];
   logic [VAL_W-1:0]  sum_mem [ENTRIES];
   logic [VAL_W-1:0]  rd_ff;
   ksa_rsp_type       rsp_ff;
   logic              strobe_ff;

   logic              hit_in;
   logic [IDX_W-1:0]  idx_in;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   logic [VAL_W-1:0]  mem_wdata;
   logic              mem_re;
   logic [IDX_W-1:0]  mem_raddr;
   logic [IDX_W-1:0]  slot;

   assign slot = count_ff[IDX_W-1:0];

   always_comb begin
      hit_in = 1'b0;
      idx_in = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (CNT_W'(i) < count_ff && key_ff[i] == req_ff.pair_key) begin
            hit_in = 1'b1;
            idx_in = IDX_W'(i);
         end
      end
   end

   assign flags.is_drain   = (req_ff.req_type == REQ_DRAIN);
   assign flags.hit        = hit_ff;
   assign flags.full       = (count_ff == CNT_W'(ENTRIES));
   assign flags.empty      = (count_ff == '0);
   assign flags.drain_last = ((CNT_W'(drain_idx_ff) + CNT_W'(1)) == count_ff);

   always_comb begin
      count_in = count_ff;
      if (cmd.append) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.drain_out && flags.drain_last) begin
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         strobe_ff <= cmd.rsp_drop || cmd.rsp_empty || cmd.drain_out;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff       <= req_data;
         drain_idx_ff <= '0;
      end else if (cmd.drain_out) begin
         drain_idx_ff <= drain_idx_ff + IDX_W'(1);
      end
      if (cmd.lookup) begin
         hit_ff <= hit_in;
         idx_ff <= idx_in;
      end
      if (cmd.append) begin
         key_ff[slot] <= req_ff.pair_key;
      end
   end

   assign mem_we    = cmd.update || cmd.append;
   assign mem_waddr = cmd.append ? slot : idx_ff;
   assign mem_wdata = cmd.append ? req_ff.pair_value : sat_add(rd_ff, req_ff.pair_value);
   assign mem_re    = cmd.hit_read || cmd.drain_read;
   assign mem_raddr = cmd.drain_read ? drain_idx_ff : idx_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         sum_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff <= sum_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_drop) begin
         rsp_ff.out_key <= req_ff.pair_key;
         rsp_ff.out_sum <= req_ff.pair_value;
         rsp_ff.status  <= CODE_FULL;
         rsp_ff.last    <= 1'b1;
      end else if (cmd.rsp_empty) begin
         rsp_ff.out_key <= '0;
         rsp_ff.out_sum <= '0;
         rsp_ff.status  <= CODE_EMPTY;
         rsp_ff.last    <= 1'b1;
      end else if (cmd.drain_out) begin
         rsp_ff.out_key <= key_ff[drain_idx_ff];
         rsp_ff.out_sum <= rd_ff;
         rsp_ff.status  <= CODE_VALID;
         rsp_ff.last    <= flags.drain_last;
      end
   end

   assign rsp_data = rsp_ff;
   assign strobe   = strobe_ff;

endmodule

`default_nettype wire

@@ hw/rtl/keyed_sum_aggregator.sv @@
// Group-by-key sum of signed Q16.16 values.
// Input: an item (req_data) is taken at a rising edge with start high and busy
// low. req_type add looks the key up among stored entries and adds the value
// with saturation, or appends a new entry in first-seen order. req_type drain
// emits all entries in insertion order and empties the table.
// Output: each result sits on rsp_data for one cycle while strobe is high;
// the receiver cannot stall, so every strobe cycle is one delivered item.
// Sequence: the controller registers the item, compares its key against every
// entry in parallel, then decides. A hit reads the stored sum in a registered
// read and writes back the saturated sum; a new key goes to the next free
// entry; a new key with the table full is dropped and returned with status
// full. A drain reads each entry in a registered read and emits it before the
// next is read; an empty drain gives a single result with status empty.
// A new item may be taken while the last result is still on the strobe.
// Reset: synchronous, active high; empties the table and drops any result.
`default_nettype none

module keyed_sum_aggregator
   import ksa_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire ksa_req_type req_data,
   output logic             busy,
   output logic             strobe,
   output ksa_rsp_type      rsp_data
);

   ksa_cmd_type   cmd;
   ksa_flags_type flags;

   ksa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .flags (flags),
      .cmd   (cmd),
      .busy  (busy)
   );

   ksa_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .flags    (flags),
      .rsp_data (rsp_data),
      .strobe   (strobe)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after accept");

   a_no_strobe_after_accept: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> !strobe)
      else $error("result right after accept");

   a_special_is_last: assert property (@(posedge clock) disable iff (reset)
      strobe && rsp_data.status != CODE_VALID |-> rsp_data.last)
      else $error("empty or drop result not marked last");

   a_strobe_from_work: assert property (@(posedge clock) disable iff (reset)
      strobe |-> $past(busy))
      else $error("result without work in progress");

endmodule

`default_nettype wire

@@ tb/keyed_sum_aggregator_tb.sv @@
`timescale 1ns / 1ps

module keyed_sum_aggregator_tb;
   import ksa_pkg::*;

   localparam int    RUN_LIMIT    = 200000;
   localparam int    RANDOM_ITEMS = 100;
   localparam int    DRAIN_WAIT   = 2000;
   localparam int    TAIL_CYCLES  = 40;
   localparam string PASS_TEXT    = "keyed_sum_aggregator regression: pass";

   logic        clock    = 1'b0;
   logic        reset    = 1'b1;
   logic        start    = 1'b0;
   ksa_req_type req_data = '0;
   logic        busy;
   logic        strobe;
   ksa_rsp_type rsp_data;

   logic [KEY_W-1:0]        model_key [ENTRIES];
   logic signed [VAL_W-1:0] model_sum [ENTRIES];
   int                      model_count = 0;

   ksa_rsp_type pending_results [$];
   ksa_rsp_type want;

   int mismatches    = 0;
   int cycle_count   = 0;
   int items_sent    = 0;
   int results_seen  = 0;
   int drains_sent   = 0;
   int drops_seen    = 0;
   int saturations   = 0;

   keyed_sum_aggregator dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_data (req_data),
      .busy     (busy),
      .strobe   (strobe),
      .rsp_data (rsp_data)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > RUN_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("keyed_sum_aggregator regression: fail");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] exp_val);
      $display("mismatch at cycle %0d, %s: got %h, expected %h",
               cycle_count, what, got, exp_val);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (!reset && strobe) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result key", rsp_data.out_key, '0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.out_key !== want.out_key)
               report_mismatch("out_key", rsp_data.out_key, want.out_key);
            if (rsp_data.out_sum !== want.out_sum)
               report_mismatch("out_sum", rsp_data.out_sum, want.out_sum);
            if (rsp_data.status !== want.status)
               report_mismatch("status", 32'(rsp_data.status), 32'(want.status));
            if (rsp_data.last !== want.last)
               report_mismatch("last", 32'(rsp_data.last), 32'(want.last));
         end
      end
   end

   task automatic expect_result(input ksa_rsp_type r);
      pending_results.insert(pending_results.size(), r);
   endtask

   task automatic aggregate_item(input ksa_req_type item);
      ksa_rsp_type r;
      int          slot;
      longint      total;
      slot = -1;
      r    = '0;
      if (item.req_type == REQ_DRAIN) begin
         drains_sent++;
         if (model_count == 0) begin
            r.status = CODE_EMPTY;
            r.last   = 1'b1;
            expect_result(r);
         end else begin
            for (int i = 0; i < model_count; i++) begin
               r.out_key = model_key[i];
               r.out_sum = model_sum[i];
               r.status  = CODE_VALID;
               r.last    = (i == model_count - 1);
               expect_result(r);
            end
         end
         model_count = 0;
      end else begin
         for (int i = 0; i < model_count; i++)
            if (slot < 0 && model_key[i] == item.pair_key)
               slot = i;
         if (slot >= 0) begin
            total = longint'($signed(model_sum[slot])) +
                    longint'($signed(item.pair_value));
            if (total > 64'sd2147483647) begin
               total = 64'sd2147483647;
               saturations++;
            end else if (total < -64'sd2147483648) begin
               total = -64'sd2147483648;
               saturations++;
            end
            model_sum[slot] = total[31:0];
         end else if (model_count < ENTRIES) begin
            model_key[model_count] = item.pair_key;
            model_sum[model_count] = item.pair_value;
            model_count++;
         end else begin
            drops_seen++;
            r.out_key = item.pair_key;
            r.out_sum = item.pair_value;
            r.status  = CODE_FULL;
            r.last    = 1'b1;
            expect_result(r);
         end
      end
   endtask

   task automatic send_item(input logic kind, input logic [KEY_W-1:0] key,
                            input logic [VAL_W-1:0] value, input int gap);
      ksa_req_type item;
      item.req_type   = kind;
      item.pair_key   = key;
      item.pair_value = value;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy !== 1'b0);
      aggregate_item(item);
      items_sent++;
   endtask

   task automatic wait_for_results;
      int waited;
      waited = 0;
      start <= 1'b0;
      do begin
         @(posedge clock);
         waited++;
      end while (pending_results.size() != 0 && waited < DRAIN_WAIT);
      if (pending_results.size() != 0) begin
         report_mismatch("results never delivered", 32'(pending_results.size()), 32'd0);
         pending_results.delete();
      end
   endtask

   function automatic int draw_gap(input bit burst);
      return burst ? 0 : $urandom_range(0, 19);
   endfunction

   function automatic logic [VAL_W-1:0] pick_value;
      case ($urandom_range(0, 6))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'($urandom_range(0, 131071)) - 32'd65536;
         default: return $urandom;
      endcase
   endfunction

   task automatic test_extremes;
      send_item(REQ_DRAIN, $urandom, $urandom, draw_gap(0));
      send_item(REQ_ADD, 32'h0000_0000, 32'h7FFF_FFFF, draw_gap(0));
      send_item(REQ_ADD, 32'h0000_0000, 32'h0000_0001, 0);
      send_item(REQ_ADD, 32'hFFFF_FFFF, 32'h8000_0000, draw_gap(0));
      send_item(REQ_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
      send_item(REQ_ADD, 32'h0000_0000, 32'h8000_0000, draw_gap(0));
      send_item(REQ_DRAIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
      send_item(REQ_DRAIN, 32'h0000_0000, 32'h0000_0000, 0);
      wait_for_results();
   endtask

   task automatic test_table_full;
      for (int i = 0; i < ENTRIES; i++)
         send_item(REQ_ADD, 32'h1000_0000 + 32'(i) * 32'h0101_0101,
                   pick_value(), (i < 8) ? 0 : draw_gap(0));
      send_item(REQ_ADD, 32'hFFFF_FFFF, 32'h8000_0000, 0);
      send_item(REQ_ADD, 32'h1000_0000, 32'h0001_0000, draw_gap(0));
      send_item(REQ_ADD, 32'h0000_0000, 32'h7FFF_FFFF, 0);
      send_item(REQ_DRAIN, $urandom, $urandom, 0);
      wait_for_results();
   endtask

   task automatic test_random_sessions;
      logic [KEY_W-1:0] pool [20];
      int               pool_size;
      int               adds;
      int               sent;
      int               paused;
      bit               burst;
      sent   = 0;
      paused = 0;
      while (sent < RANDOM_ITEMS) begin
         burst = ($urandom_range(0, 2) == 0);
         if ($urandom_range(0, 9) == 0) begin
            send_item(logic'($urandom_range(0, 1)), $urandom, pick_value(),
                      draw_gap(burst));
            sent++;
         end else begin
            pool_size = $urandom_range(1, 20);
            for (int i = 0; i < pool_size; i++)
               case ($urandom_range(0, 9))
                  0: pool[i] = 32'h0000_0000;
                  1: pool[i] = 32'hFFFF_FFFF;
                  default: pool[i] = $urandom;
               endcase
            adds = $urandom_range(1, 24);
            for (int i = 0; i < adds; i++)
               send_item(REQ_ADD, pool[$urandom_range(0, pool_size - 1)],
                         pick_value(), draw_gap(burst));
            send_item(REQ_DRAIN, $urandom, $urandom, draw_gap(burst));
            sent += adds + 1;
         end
         if (!paused && sent >= RANDOM_ITEMS / 2) begin
            paused = 1;
            wait_for_results();
         end
      end
      wait_for_results();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_table_full();
      test_random_sessions();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d items: %0d drains, %0d dropped pairs, %0d saturated sums",
               items_sent, drains_sent, drops_seen, saturations);
      $display("checked %0d results in %0d cycles, %0d mismatches",
               results_seen, cycle_count, mismatches);
      if (mismatches == 0)
         $display(PASS_TEXT);
      else
         $display("keyed_sum_aggregator regression: fail");
      $finish;
   end

endmodule
